FILE: sv/stack_with_pop_until_match_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack with pop-until-match
// Implication checks on the rising clock edge, switched off by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_POP_UNTIL_MATCH_ASSERT_SVH
`define STACK_WITH_POP_UNTIL_MATCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SWPU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SWPU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SWPU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SWPU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/swpu_pkg.sv
// ----------------------------------------------------------------------------
// swpu_pkg
// Shared types and codes of the stack with pop-until-match.
// ----------------------------------------------------------------------------
package swpu_pkg;

   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_PUSH      = 2'd0,
      OP_POP       = 2'd1,
      OP_POP_UNTIL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RSP_OK        = 2'd0,
      RSP_EMPTY     = 2'd1,
      RSP_NOT_FOUND = 2'd2,
      RSP_FULL      = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DRAIN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic           load;       // capture request
      logic           push;       // write value at fill count, count++
      logic           rd_top;     // read entry at count-1
      logic           rd_next;    // ptr--, read entry at new ptr
      logic           ptr_set;    // ptr <= count-1
      logic           cnt_dec;    // count--
      logic           emit;       // produce a result next cycle
      logic           emit_word;  // result carries the read word
      rsp_status_type status;
      logic           last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       full;
      logic       match;      // read word equals request value
      logic       ptr_zero;
      logic       drain_last; // entry just read is the match
   } dp_sts_type;

endpackage

FILE: sv/swpu_ctrl.sv
// ----------------------------------------------------------------------------
// swpu_ctrl
// Controller: sequences push, pop, search and drain over the datapath.
// ----------------------------------------------------------------------------
`include "stack_with_pop_until_match_assert.svh"

module swpu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  swpu_pkg::dp_sts_type sts,
   output swpu_pkg::dp_cmd_type cmd
);

   swpu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swpu_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = swpu_pkg::RSP_OK;
      unique case (state_ff)
         swpu_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = swpu_pkg::S_EXEC;
            end
         end
         swpu_pkg::S_EXEC: begin
            state_in = swpu_pkg::S_IDLE;
            unique case (sts.op)
               swpu_pkg::OP_PUSH: begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                  if (sts.full) begin
                     cmd.status = swpu_pkg::RSP_FULL;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               swpu_pkg::OP_POP: begin
                  if (sts.empty) begin
                     cmd.emit   = 1'b1;
                     cmd.last   = 1'b1;
                     cmd.status = swpu_pkg::RSP_EMPTY;
                  end else begin
                     // single-entry drain: match index is the top itself
                     cmd.ptr_set = 1'b1;
                     cmd.rd_top  = 1'b1;
                     cmd.cnt_dec = 1'b1;
                     state_in    = swpu_pkg::S_DRAIN;
                  end
               end
               swpu_pkg::OP_POP_UNTIL: begin
                  if (sts.empty) begin
                     cmd.emit   = 1'b1;
                     cmd.last   = 1'b1;
                     cmd.status = swpu_pkg::RSP_NOT_FOUND;
                  end else begin
                     cmd.ptr_set = 1'b1;
                     cmd.rd_top  = 1'b1;
                     state_in    = swpu_pkg::S_SCAN;
                  end
               end
               default: ;
            endcase
         end
         swpu_pkg::S_SCAN: begin
            if (sts.match) begin
               cmd.rd_top  = 1'b1;
               cmd.cnt_dec = 1'b1;
               state_in    = swpu_pkg::S_DRAIN;
            end else if (sts.ptr_zero) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.status = swpu_pkg::RSP_NOT_FOUND;
               state_in   = swpu_pkg::S_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         swpu_pkg::S_DRAIN: begin
            cmd.emit      = 1'b1;
            cmd.emit_word = 1'b1;
            cmd.last      = sts.drain_last;
            if (sts.drain_last) begin
               state_in = swpu_pkg::S_IDLE;
            end else begin
               cmd.rd_top  = 1'b1;
               cmd.cnt_dec = 1'b1;
            end
         end
         default: state_in = swpu_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != swpu_pkg::S_IDLE);

   `SWPU_ASSERT_NXT(a_last_ends_item, clock, reset, cmd.emit && cmd.last,
                    state_ff == swpu_pkg::S_IDLE)
   `SWPU_ASSERT_IMP(a_drain_not_empty, clock, reset,
                    (state_ff == swpu_pkg::S_DRAIN) && !sts.drain_last, !sts.empty)
   `SWPU_ASSERT_IMP(a_load_when_idle, clock, reset, cmd.load, !busy)

endmodule

FILE: sv/swpu_dp.sv
// ----------------------------------------------------------------------------
// swpu_dp
// Datapath: entry memory, fill count, scan pointer and result register.
// ----------------------------------------------------------------------------
`include "stack_with_pop_until_match_assert.svh"

module swpu_dp #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_op,
   input  swpu_pkg::word_type     req_value,
   input  swpu_pkg::dp_cmd_type   cmd,
   output swpu_pkg::dp_sts_type   sts,
   output logic                   rsp_valid,
   output swpu_pkg::word_type     rsp_popped,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [swpu_pkg::WORD_W-1:0] mem [DEPTH];

   logic [1:0]         op_ff;
   swpu_pkg::word_type value_ff;
   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      ptr_ff;
   swpu_pkg::word_type rd_data_ff;

   logic               rsp_valid_ff;
   swpu_pkg::word_type rsp_popped_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_last_ff;

   logic [CW-1:0]      count_m1;
   logic [AW-1:0]      top_idx;
   logic [AW-1:0]      ptr_m1;
   logic [AW-1:0]      rd_addr;
   logic               rd_en;

   assign count_m1 = count_ff - CW'(1);
   assign top_idx  = count_m1[AW-1:0];
   assign ptr_m1   = ptr_ff - AW'(1);
   assign rd_addr  = cmd.rd_next ? ptr_m1 : top_idx;
   assign rd_en    = cmd.rd_top | cmd.rd_next;

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[count_ff[AW-1:0]] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      if (cmd.ptr_set) begin
         ptr_ff <= top_idx;
      end else if (cmd.rd_next) begin
         ptr_ff <= ptr_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_ff <= count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_popped_ff <= cmd.emit_word ? rd_data_ff : '0;
         rsp_status_ff <= cmd.status;
         rsp_last_ff   <= cmd.last;
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.empty      = (count_ff == '0);
      sts.full       = (count_ff == CW'(DEPTH));
      sts.match      = (rd_data_ff == value_ff);
      sts.ptr_zero   = (ptr_ff == '0);
      sts.drain_last = (count_ff == CW'(ptr_ff));
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_popped = rsp_popped_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   `SWPU_ASSERT_NXT(a_push_incr, clock, reset, cmd.push,
                    count_ff == $past(count_ff) + CW'(1))
   `SWPU_ASSERT_IMP(a_push_not_full, clock, reset, cmd.push, !sts.full)
   `SWPU_ASSERT_IMP(a_pop_not_empty, clock, reset, cmd.cnt_dec, !sts.empty)

endmodule

FILE: sv/stack_with_pop_until_match.sv
// ----------------------------------------------------------------------------
// stack_with_pop_until_match
// Bounded LIFO of signed 32-bit words with push, pop and pop-until-value.
// ----------------------------------------------------------------------------
// A request (req_op, req_value) is taken on a clock edge with start high and
// busy low. Results come out on rsp_popped/rsp_status/rsp_last, each valid for
// exactly one cycle with rsp_valid; the receiver cannot stall them. rsp_last
// marks the final result of a request.
// Each result is registered and shown in the cycle after it is issued.
// pop-until compares entries from the top, one per cycle (limited by the
// single memory read port), then pops the entries down to the match, one
// result per cycle while draining. Not found: every entry is compared and
// none is popped.
// One request is in flight at a time; the next may be accepted in the cycle
// its last result is shown.
// Reset empties the stack (fill count zero) and returns to idle; the entry
// memory itself is not cleared, only entries below the fill count are read.
// ----------------------------------------------------------------------------
module stack_with_pop_until_match #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_popped,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   swpu_pkg::dp_cmd_type cmd;
   swpu_pkg::dp_sts_type sts;

   swpu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   swpu_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_value  (req_value),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack with pop-until-match. Requests go in
// through the start/busy handshake; a shadow stack predicts every result and a
// checker compares each strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH = 64;
   localparam logic [1:0] OP_UNUSED = 2'd3;   // not decoded; block ignores it
   localparam int DRAIN_LIMIT = 400;          // upper bound on the wait for outstanding results
   localparam int TAIL_CYCLES = 140;
   localparam int RANDOM_REQUESTS = 70;

   typedef struct packed {
      swpu_pkg::word_type       popped;
      swpu_pkg::rsp_status_type status;
      logic                     last;
   } stack_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [1:0]          req_op = swpu_pkg::OP_PUSH;
   swpu_pkg::word_type  req_value = '0;
   logic                busy;
   logic                rsp_valid;
   swpu_pkg::word_type  rsp_popped;
   logic [1:0]          rsp_status;
   logic                rsp_last;

   stack_result_type    expected_q[$];
   swpu_pkg::word_type  shadow_stack[DEPTH];
   int                  shadow_count = 0;
   int                  fail_count = 0;

   stack_with_pop_until_match #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow stack
   // ------------------------------------------------------------------------
   function automatic void expect_result(swpu_pkg::word_type popped,
                                         swpu_pkg::rsp_status_type status,
                                         logic last);
      stack_result_type r;
      r.popped = popped;
      r.status = status;
      r.last   = last;
      expected_q.push_back(r);
   endfunction

   function automatic void predict_request(logic [1:0] op, swpu_pkg::word_type value);
      int match_idx;
      match_idx = -1;
      case (op)
         swpu_pkg::OP_PUSH: begin
            if (shadow_count >= DEPTH) begin
               expect_result('0, swpu_pkg::RSP_FULL, 1'b1);
            end else begin
               shadow_stack[shadow_count] = value;
               shadow_count++;
               expect_result('0, swpu_pkg::RSP_OK, 1'b1);
            end
         end
         swpu_pkg::OP_POP: begin
            if (shadow_count == 0) begin
               expect_result('0, swpu_pkg::RSP_EMPTY, 1'b1);
            end else begin
               shadow_count--;
               expect_result(shadow_stack[shadow_count], swpu_pkg::RSP_OK, 1'b1);
            end
         end
         swpu_pkg::OP_POP_UNTIL: begin
            // topmost match wins
            for (int i = shadow_count - 1; i >= 0 && match_idx < 0; i--)
               if (shadow_stack[i] == value)
                  match_idx = i;
            if (match_idx < 0) begin
               expect_result('0, swpu_pkg::RSP_NOT_FOUND, 1'b1);
            end else begin
               while (shadow_count > match_idx) begin
                  shadow_count--;
                  expect_result(shadow_stack[shadow_count], swpu_pkg::RSP_OK,
                                shadow_count == match_idx);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver; called at a falling edge, returns at a falling edge.
   // start is left high so back-to-back requests keep it asserted.
   // ------------------------------------------------------------------------
   task automatic send_request(logic [1:0] op, swpu_pkg::word_type value);
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (busy);
      predict_request(op, value);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_for_results();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_q.size());
         fail_count++;
         expected_q.delete();
      end
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      stack_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result: popped %0d status %0d last %0b",
                   rsp_popped, rsp_status, rsp_last);
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_popped !== exp_r.popped) begin
               $error("popped: expected %0d, got %0d", exp_r.popped, rsp_popped);
               fail_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last: expected %0b, got %0b", exp_r.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_empty_stack();
      send_request(swpu_pkg::OP_POP, '0);
      send_request(swpu_pkg::OP_POP_UNTIL, '0);
      send_request(OP_UNUSED, 32'sh7FFF_FFFF);
      wait_for_results();
   endtask

   task automatic test_directed_values();
      send_request(swpu_pkg::OP_PUSH, 32'sh8000_0000);
      send_request(swpu_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      send_request(swpu_pkg::OP_PUSH, 32'sh0000_0000);
      send_request(swpu_pkg::OP_PUSH, -32'sd1);
      send_request(swpu_pkg::OP_PUSH, 32'sh5555_5555);
      send_request(swpu_pkg::OP_PUSH, 32'shAAAA_AAAA);
      send_request(swpu_pkg::OP_PUSH, 32'sh0000_0000);
      send_request(swpu_pkg::OP_POP, '0);
      send_request(swpu_pkg::OP_POP_UNTIL, 32'sd12345);    // absent, stack unchanged
      send_request(swpu_pkg::OP_POP_UNTIL, -32'sd1);       // three entries come off
      send_request(OP_UNUSED, 32'sh5555_5555);
      send_request(swpu_pkg::OP_PUSH, 32'sd7);
      send_request(swpu_pkg::OP_PUSH, 32'sd7);
      send_request(swpu_pkg::OP_PUSH, 32'sd9);
      send_request(swpu_pkg::OP_PUSH, 32'sd3);
      send_request(swpu_pkg::OP_POP_UNTIL, 32'sd3);        // match on top, single result
      send_request(swpu_pkg::OP_POP_UNTIL, 32'sd7);        // stops at upper duplicate
      pause_sender(2);
      send_request(swpu_pkg::OP_POP_UNTIL, 32'sh8000_0000); // down to the bottom
      send_request(swpu_pkg::OP_POP, '0);
      wait_for_results();
   endtask

   task automatic test_full_stack();
      for (int i = 0; i < DEPTH; i++)
         send_request(swpu_pkg::OP_PUSH, swpu_pkg::word_type'($urandom));
      send_request(swpu_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      send_request(swpu_pkg::OP_PUSH, 32'sh8000_0000);
      send_request(swpu_pkg::OP_POP_UNTIL, shadow_stack[0]);
      wait_for_results();
   endtask

   task automatic test_random_ops();
      int sent;
      int burst_left;
      int pick;
      int push_weight;
      logic [1:0] op;
      swpu_pkg::word_type value;
      sent = 0;
      burst_left = $urandom_range(1, 12);
      while (sent < RANDOM_REQUESTS) begin
         // alternate between growing and shrinking phases to reach depth
         push_weight = ((sent / 30) % 2 == 0) ? 70 : 35;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            op = OP_UNUSED;
         else if (pick < push_weight)
            op = swpu_pkg::OP_PUSH;
         else if (pick < push_weight + (100 - push_weight) / 3)
            op = swpu_pkg::OP_POP;
         else
            op = swpu_pkg::OP_POP_UNTIL;

         if ($urandom_range(0, 1) == 0) begin
            value = $urandom_range(0, 7);
            value = value - 4;                  // small pool makes duplicates
         end else begin
            value = $urandom;
         end
         if (op == swpu_pkg::OP_POP_UNTIL && shadow_count > 0 && $urandom_range(0, 3) != 0)
            value = shadow_stack[$urandom_range(0, shadow_count - 1)];

         send_request(op, value);
         if (op != OP_UNUSED)
            sent++;

         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0)
               wait_for_results();
            else
               pause_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_stack();
      test_directed_values();
      test_full_stack();
      test_random_ops();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("stack_with_pop_until_match verification clean");
      else
         $display("stack_with_pop_until_match verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("stack_with_pop_until_match verification failed");
      $finish;
   end

endmodule
